// File: hdl/cds_pkg.sv
// shared types, constants and calendar helpers for the calendar date subtractor
package cds_pkg;

	localparam int FUNC_W  = 3;
	localparam int COUNT_W = 15;
	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 16;
	localparam int REM_W   = 18;	// day budget, up to 7 * 32767
	localparam int RES_W   = 9;	// year modulo 400
	localparam int ACC_W   = 16;
	localparam int STEP_W  = 3;

	typedef enum logic [FUNC_W-1:0] {
		FN_DAYS       = 3'd0,
		FN_WEEKS      = 3'd1,
		FN_MONTHS     = 3'd2,
		FN_YEARS      = 3'd3,
		FN_DECADES    = 3'd4,
		FN_CENTURY    = 3'd5,
		FN_MILLENNIUM = 3'd6
	} func_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RES_STEP,
		ST_RES_FIX,
		ST_CLAMP,
		ST_YEAR_SUB,
		ST_DAY_STEP,
		ST_MONTH_STEP,
		ST_DONE
	} state_t;

	localparam logic [RES_W-1:0]   RES_MOD    = 9'd400;
	localparam logic [RES_W-1:0]   RES_BIAS   = 9'd32;	// (-32768) mod 400 is 32
	localparam logic [RES_W-1:0]   RES_WRAP   = 9'd367;	// 32767 mod 400
	localparam logic [RES_W-1:0]   RES_LAST   = 9'd399;
	localparam logic [YEAR_W-1:0]  YEAR_MIN   = 16'h8000;
	localparam logic [YEAR_W-1:0]  CENTURY    = 16'd100;
	localparam logic [YEAR_W-1:0]  MILLENNIUM = 16'd1000;
	localparam logic [MONTH_W-1:0] JAN        = 4'd1;
	localparam logic [MONTH_W-1:0] FEB        = 4'd2;
	localparam logic [MONTH_W-1:0] APR        = 4'd4;
	localparam logic [MONTH_W-1:0] JUN        = 4'd6;
	localparam logic [MONTH_W-1:0] SEP        = 4'd9;
	localparam logic [MONTH_W-1:0] NOV        = 4'd11;
	localparam logic [MONTH_W-1:0] DEC        = 4'd12;
	localparam logic [DAY_W-1:0]   DAY_FIRST  = 5'd1;
	localparam logic [DAY_W-1:0]   DAY_31     = 5'd31;
	localparam logic [DAY_W-1:0]   DAY_30     = 5'd30;
	localparam logic [DAY_W-1:0]   DAY_29     = 5'd29;
	localparam logic [DAY_W-1:0]   DAY_28     = 5'd28;

	// 4/100/400 rule on the year residue modulo 400
	function automatic logic is_leap(input logic [RES_W-1:0] res);
		return (res[1:0] == 2'b00) && (res != 9'd100) && (res != 9'd200)
			&& (res != 9'd300);
	endfunction

	function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] n;
		if (m == FEB) begin
			n = leap ? DAY_29 : DAY_28;
		end else if (m inside {APR, JUN, SEP, NOV}) begin
			n = DAY_30;
		end else begin
			n = DAY_31;
		end
		return n;
	endfunction

	// residue of year - 1, with the 16-bit wrap from the lowest year to the highest
	function automatic logic [RES_W-1:0] res_dec(input logic [RES_W-1:0] res,
		input logic [YEAR_W-1:0] year);
		logic [RES_W-1:0] r;
		if (year == YEAR_MIN) begin
			r = RES_WRAP;
		end else if (res == '0) begin
			r = RES_LAST;
		end else begin
			r = res - 9'd1;
		end
		return r;
	endfunction

endpackage

// File: hdl/calendar_date_subtractor.sv
// top level: gregorian date subtraction by days, weeks, months, years, decades, centuries or millennia
// order: accept, year residue, clamp, then
//   days/weeks: back one month border at a time, then the day; months: back one month at a time;
//   year codes: subtract, residue again, clamp; then the output register
// throughput: one item at a time, the input stalls from accept until its result is in
//   the output register; the output register frees the input while the result waits
// reset: arst_n clears the sequencer and the result valid, no data register is reset
module calendar_date_subtractor (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic [cds_pkg::FUNC_W-1:0]         func,
	input  logic [cds_pkg::COUNT_W-1:0]        count,
	input  logic [cds_pkg::DAY_W-1:0]          day,
	input  logic [cds_pkg::MONTH_W-1:0]        month,
	input  logic signed [cds_pkg::YEAR_W-1:0]  year,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic [cds_pkg::DAY_W-1:0]          new_day,
	output logic [cds_pkg::MONTH_W-1:0]        new_month,
	output logic signed [cds_pkg::YEAR_W-1:0]  new_year
);
	import cds_pkg::*;

	// sequencer and working registers
	state_t              state_q, state_d;
	logic [FUNC_W-1:0]   func_q, func_d;
	logic [COUNT_W-1:0]  count_q, count_d;	// also the month step counter
	logic [DAY_W-1:0]    day_q, day_d;
	logic [MONTH_W-1:0]  month_q, month_d;
	logic [YEAR_W-1:0]   year_q, year_d;
	logic [ACC_W-1:0]    acc_q, acc_d;	// biased year being reduced modulo 400
	logic [STEP_W-1:0]   step_q, step_d;
	logic [RES_W-1:0]    res_q, res_d;	// year modulo 400, floor convention
	logic [REM_W-1:0]    rem_q, rem_d;	// days still to go back
	logic                second_q, second_d;	// residue pass after a year subtract

	// output register
	logic                result_valid_q;
	logic [DAY_W-1:0]    new_day_q;
	logic [MONTH_W-1:0]  new_month_q;
	logic [YEAR_W-1:0]   new_year_q;
	logic                out_load;

	// shared subtractor: residue reduction, day stepping and year subtraction
	logic [REM_W-1:0]    sub_a, sub_b;
	logic [REM_W:0]      diff;
	logic                borrow;

	// helpers
	logic                leap_cur;
	logic [DAY_W-1:0]    len_cur;
	logic [RES_W:0]      res_sum;
	logic [YEAR_W-1:0]   year_delta;
	logic [YEAR_W-1:0]   decade_w;
	logic [REM_W-1:0]    weeks_w;
	logic [MONTH_W-1:0]  m_prev;
	logic [YEAR_W-1:0]   y_prev;
	logic [RES_W-1:0]    r_prev;
	logic [DAY_W-1:0]    len_prev;

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign new_day      = new_day_q;
	assign new_month    = new_month_q;
	assign new_year     = new_year_q;

	assign leap_cur = is_leap(res_q);
	assign len_cur  = days_in(month_q, leap_cur);
	assign res_sum  = {1'b0, acc_q[RES_W-1:0]} + {1'b0, RES_BIAS};

	// count * 10 and count * 7 built from shifts
	assign decade_w = {count_q[12:0], 3'b000} + {count_q, 1'b0};
	assign weeks_w  = {count_q, 3'b000} - {3'b000, count_q};

	// the month before the current one, wrapping into december of the year before
	always_comb begin
		if (month_q == JAN) begin
			m_prev = DEC;
			y_prev = year_q - 16'd1;
			r_prev = res_dec(res_q, year_q);
		end else begin
			m_prev = month_q - 4'd1;
			y_prev = year_q;
			r_prev = res_q;
		end
		len_prev = days_in(m_prev, is_leap(r_prev));
	end

	always_comb begin
		case (func_q)
			FN_YEARS:   year_delta = {1'b0, count_q};
			FN_DECADES: year_delta = decade_w;
			FN_CENTURY: year_delta = CENTURY;
			default:    year_delta = MILLENNIUM;
		endcase
	end

	always_comb begin
		case (state_q)
			ST_RES_STEP: begin
				sub_a = {2'b00, acc_q};
				sub_b = {9'd0, RES_MOD} << step_q;
			end
			ST_DAY_STEP: begin
				sub_a = rem_q;
				sub_b = {13'd0, day_q};
			end
			ST_YEAR_SUB: begin
				sub_a = {2'b00, year_q};
				sub_b = {2'b00, year_delta};
			end
			default: begin
				sub_a = '0;
				sub_b = '0;
			end
		endcase
	end

	assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
	assign borrow = diff[REM_W];

	// next state and datapath control
	always_comb begin
		state_d  = state_q;
		func_d   = func_q;
		count_d  = count_q;
		day_d    = day_q;
		month_d  = month_q;
		year_d   = year_q;
		acc_d    = acc_q;
		step_d   = step_q;
		res_d    = res_q;
		rem_d    = rem_q;
		second_d = second_q;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					func_d  = func;
					count_d = count;
					day_d   = day;
					// month zero reads as january, anything past twelve as december
					if (month == '0) begin
						month_d = JAN;
					end else if (month > DEC) begin
						month_d = DEC;
					end else begin
						month_d = month;
					end
					year_d   = year;
					// flip the sign bit: offset binary keeps the reduction unsigned
					acc_d    = {~year[YEAR_W-1], year[YEAR_W-2:0]};
					step_d   = '1;
					second_d = 1'b0;
					state_d  = ST_RES_STEP;
				end
			end
			ST_RES_STEP: begin
				// restoring reduction by 400 shifted down one place per cycle
				if (!borrow) begin
					acc_d = diff[ACC_W-1:0];
				end
				if (step_q == '0) begin
					state_d = ST_RES_FIX;
				end else begin
					step_d = step_q - 3'd1;
				end
			end
			ST_RES_FIX: begin
				// undo the offset of the sign flip
				if (res_sum >= {1'b0, RES_MOD}) begin
					res_d = RES_W'(res_sum - {1'b0, RES_MOD});
				end else begin
					res_d = res_sum[RES_W-1:0];
				end
				state_d = ST_CLAMP;
			end
			ST_CLAMP: begin
				if (day_q == '0) begin
					day_d = DAY_FIRST;
				end else if (day_q > len_cur) begin
					day_d = len_cur;
				end
				if (second_q) begin
					state_d = ST_DONE;
				end else begin
					case (func_q)
						FN_DAYS: begin
							rem_d   = {3'b000, count_q};
							state_d = ST_DAY_STEP;
						end
						FN_WEEKS: begin
							rem_d   = weeks_w;
							state_d = ST_DAY_STEP;
						end
						FN_MONTHS: state_d = ST_MONTH_STEP;
						FN_YEARS, FN_DECADES, FN_CENTURY, FN_MILLENNIUM: begin
							state_d = ST_YEAR_SUB;
						end
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_YEAR_SUB: begin
				// wraps modulo 2^16, then the residue runs again for the new year
				year_d   = diff[YEAR_W-1:0];
				acc_d    = {~diff[YEAR_W-1], diff[YEAR_W-2:0]};
				step_d   = '1;
				second_d = 1'b1;
				state_d  = ST_RES_STEP;
			end
			ST_DAY_STEP: begin
				if (borrow) begin
					// budget fits inside the current month
					day_d   = day_q - rem_q[DAY_W-1:0];
					state_d = ST_DONE;
				end else begin
					// spend the days of this month, land on the last day of the one before
					rem_d   = diff[REM_W-1:0];
					month_d = m_prev;
					year_d  = y_prev;
					res_d   = r_prev;
					day_d   = len_prev;
				end
			end
			ST_MONTH_STEP: begin
				if (count_q == '0) begin
					state_d = ST_DONE;
				end else begin
					count_d = count_q - 15'd1;
					month_d = m_prev;
					year_d  = y_prev;
					res_d   = r_prev;
					if (day_q > len_prev) begin
						day_d = len_prev;
					end
				end
			end
			ST_DONE: begin
				if (!result_valid_q || !result_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		func_q   <= func_d;
		count_q  <= count_d;
		day_q    <= day_d;
		month_q  <= month_d;
		year_q   <= year_d;
		acc_q    <= acc_d;
		step_q   <= step_d;
		res_q    <= res_d;
		rem_q    <= rem_d;
		second_q <= second_d;
		if (out_load) begin
			new_day_q   <= day_q;
			new_month_q <= month_q;
			new_year_q  <= year_q;
		end
	end

endmodule
